[rtl/core/hm_pkg.sv]
// Shared types and constants for the height map sampler.
`timescale 1ns / 1ps

package hm_pkg;

    localparam int COORD_W     = 17;
    localparam int IDX_W       = 8;
    localparam int SAMPLE_W    = 8;
    localparam int DIM_W       = 9;
    localparam int HEIGHT_W    = 24;
    localparam int OUT_FRAC    = 16;
    localparam int CFG_INDEX_W = 1;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    localparam logic [DIM_W-1:0] DIM_RESET = 9'd256;

    typedef enum logic
    {
        REQ_WRITE = 1'b0,
        REQ_QUERY = 1'b1
    } req_type_t;

    typedef enum logic [CFG_INDEX_W-1:0]
    {
        CFG_MAP_WIDTH  = 1'b0,
        CFG_MAP_LENGTH = 1'b1
    } cfg_index_t;

    typedef struct packed
    {
        logic                is_query;
        logic                write_ok;
        logic                outside;
        logic                clamp_x;
        logic                clamp_z;
        logic [IDX_W-1:0]    write_col;
        logic [IDX_W-1:0]    write_row;
        logic [SAMPLE_W-1:0] write_value;
        logic [COORD_W-1:0]  query_x;
        logic [COORD_W-1:0]  query_z;
    } item_t;

    typedef struct packed
    {
        logic full;
        logic empty;
    } qstat_t;

endpackage

[rtl/core/hm_if.sv]
// Request and response channel interfaces of the height map sampler.
`timescale 1ns / 1ps

interface hm_req_if;
    logic                                valid;
    logic                                ready;
    logic                                req_type;
    logic [hm_pkg::IDX_W-1:0]            write_col;
    logic [hm_pkg::IDX_W-1:0]            write_row;
    logic [hm_pkg::SAMPLE_W-1:0]         write_value;
    logic signed [hm_pkg::COORD_W-1:0]   query_x;
    logic signed [hm_pkg::COORD_W-1:0]   query_z;

    modport source
    (
        output valid, req_type, write_col, write_row, write_value, query_x, query_z,
        input  ready
    );

    modport sink
    (
        input  valid, req_type, write_col, write_row, write_value, query_x, query_z,
        output ready
    );
endinterface

interface hm_rsp_if;
    logic                         valid;
    logic                         ready;
    logic [hm_pkg::HEIGHT_W-1:0]  height;
    logic                         outside;

    modport source
    (
        output valid, height, outside,
        input  ready
    );

    modport sink
    (
        input  valid, height, outside,
        output ready
    );
endinterface

[rtl/core/hm_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module hm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
)
(
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[rtl/core/hm_front.sv]
// Front end: configuration registers, request acceptance and classification.
`timescale 1ns / 1ps

module hm_front #(
    parameter int MAP_SIZE  = 256,
    parameter int FRAC_BITS = 8
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [hm_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [hm_pkg::DIM_W-1:0]        cfg_data,
    hm_req_if.sink                          req,
    input  hm_pkg::qstat_t                  q_stat,
    output logic                            q_push,
    output hm_pkg::item_t                   q_item
);

    localparam int CW_ = hm_pkg::COORD_W;
    localparam logic [CW_-1:0] SIZE_C = CW_'(MAP_SIZE);

    logic [hm_pkg::DIM_W-1:0] map_width_reg;
    logic [hm_pkg::DIM_W-1:0] map_length_reg;
    logic [CW_-1:0]           width_eff;
    logic [CW_-1:0]           length_eff;
    logic [CW_-1:0]           ix;
    logic [CW_-1:0]           iz;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            map_width_reg  <= hm_pkg::DIM_RESET;
            map_length_reg <= hm_pkg::DIM_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                hm_pkg::CFG_MAP_WIDTH:  map_width_reg  <= cfg_data;
                hm_pkg::CFG_MAP_LENGTH: map_length_reg <= cfg_data;
            endcase
        end
    end

    always_comb
    begin
        width_eff  = (CW_'(map_width_reg) > SIZE_C) ? SIZE_C : CW_'(map_width_reg);
        length_eff = (CW_'(map_length_reg) > SIZE_C) ? SIZE_C : CW_'(map_length_reg);
        ix = CW_'(req.query_x[CW_-1:FRAC_BITS]);
        iz = CW_'(req.query_z[CW_-1:FRAC_BITS]);

        q_item.is_query    = (req.req_type == hm_pkg::REQ_QUERY);
        q_item.write_ok    = (CW_'(req.write_col) < SIZE_C) && (CW_'(req.write_row) < SIZE_C);
        q_item.outside     = req.query_x[CW_-1] || req.query_z[CW_-1] ||
                             (ix >= width_eff) || (iz >= length_eff);
        q_item.clamp_x     = (ix + CW_'(1)) >= width_eff;
        q_item.clamp_z     = (iz + CW_'(1)) >= length_eff;
        q_item.write_col   = req.write_col;
        q_item.write_row   = req.write_row;
        q_item.write_value = req.write_value;
        q_item.query_x     = req.query_x;
        q_item.query_z     = req.query_z;
    end

    assign req.ready = !q_stat.full;
    assign q_push    = req.valid && !q_stat.full;

endmodule

[rtl/core/hm_queue.sv]
// Short request queue between front end and back end.
`timescale 1ns / 1ps

module hm_queue
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  hm_pkg::item_t   din,
    input  logic            pop,
    output hm_pkg::item_t   dout,
    output hm_pkg::qstat_t  stat
);

    localparam int PW = hm_pkg::QPTR_W;

    hm_pkg::item_t   mem_reg [hm_pkg::QUEUE_DEPTH];
    logic [PW-1:0]   wr_ptr_reg;
    logic [PW-1:0]   rd_ptr_reg;
    logic [PW:0]     count_reg;
    logic [PW:0]     count_next;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= din;
        end
    end

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + (PW+1)'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - (PW+1)'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + PW'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + PW'(1);
            end
            count_reg <= count_next;
        end
    end

    assign dout       = mem_reg[rd_ptr_reg];
    assign stat.full  = (count_reg == (PW+1)'(hm_pkg::QUEUE_DEPTH));
    assign stat.empty = (count_reg == '0);

endmodule

[rtl/core/hm_back.sv]
// Back end: banked sample store, corner fixup and bilinear interpolation pipeline.
`timescale 1ns / 1ps

module hm_back #(
    parameter int MAP_SIZE  = 256,
    parameter int FRAC_BITS = 8
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  hm_pkg::qstat_t  q_stat,
    input  hm_pkg::item_t   q_item,
    output logic            q_pop,
    hm_rsp_if.source        rsp
);

    localparam int CW     = (MAP_SIZE > 4) ? $clog2(MAP_SIZE) : 2;
    localparam int AW     = 2 * (CW - 1);
    localparam int DEPTH  = 1 << AW;
    localparam int ONE    = 1 << FRAC_BITS;
    localparam int CRN_W  = hm_pkg::SAMPLE_W + 2;
    localparam int WGT_W  = FRAC_BITS + 2;
    localparam int LIN_W  = CRN_W + WGT_W;
    localparam int PRD_W  = LIN_W + WGT_W;
    localparam int H_W    = PRD_W + 1;
    localparam int EXT_W  = H_W + hm_pkg::OUT_FRAC;
    localparam int SH     = 2 * FRAC_BITS - hm_pkg::OUT_FRAC;
    localparam int HT_W   = hm_pkg::HEIGHT_W;
    localparam int CO_W   = hm_pkg::COORD_W;

    localparam logic signed [WGT_W-1:0] ONE_W  = WGT_W'(ONE);
    localparam logic [FRAC_BITS:0]      ONE_F  = (FRAC_BITS+1)'(ONE);

    logic                         advance;
    logic [CW-1:0]                ix;
    logic [CW-1:0]                iz;
    logic [CW-1:0]                ix1;
    logic [CW-1:0]                iz1;
    logic [CW-1:0]                wr_col;
    logic [CW-1:0]                wr_row;
    logic [hm_pkg::SAMPLE_W-1:0]  bank_data [4];

    // stage 1: bank read in flight
    logic                         s1_valid_reg;
    logic                         s1_outside_reg;
    logic [FRAC_BITS-1:0]         s1_fx_reg;
    logic [FRAC_BITS-1:0]         s1_fz_reg;
    logic                         s1_ix0_reg;
    logic                         s1_iz0_reg;
    logic                         s1_clamp_x_reg;
    logic                         s1_clamp_z_reg;

    // stage 2: corners after fixup
    logic                         s2_valid_reg;
    logic                         s2_outside_reg;
    logic [FRAC_BITS-1:0]         s2_fx_reg;
    logic [FRAC_BITS-1:0]         s2_fz_reg;
    logic signed [CRN_W-1:0]      s2_bl_reg;
    logic signed [CRN_W-1:0]      s2_br_reg;
    logic signed [CRN_W-1:0]      s2_tl_reg;
    logic signed [CRN_W-1:0]      s2_tr_reg;

    // stage 3: row blends
    logic                         s3_valid_reg;
    logic                         s3_outside_reg;
    logic [FRAC_BITS-1:0]         s3_fz_reg;
    logic signed [LIN_W-1:0]      s3_top_reg;
    logic signed [LIN_W-1:0]      s3_bot_reg;

    // stage 4: weighted rows
    logic                         s4_valid_reg;
    logic                         s4_outside_reg;
    logic signed [PRD_W-1:0]      s4_ptop_reg;
    logic signed [PRD_W-1:0]      s4_pbot_reg;

    logic                         out_valid_reg;
    logic [HT_W-1:0]              height_reg;
    logic                         outside_reg;

    logic signed [CRN_W-1:0]      c_bl;
    logic signed [CRN_W-1:0]      c_br;
    logic signed [CRN_W-1:0]      c_tl;
    logic signed [CRN_W-1:0]      c_tr;
    logic signed [LIN_W-1:0]      top_next;
    logic signed [LIN_W-1:0]      bot_next;
    logic signed [PRD_W-1:0]      ptop_next;
    logic signed [PRD_W-1:0]      pbot_next;
    logic signed [H_W-1:0]        h_sum;
    logic [EXT_W-1:0]             h_ext;
    logic [EXT_W-1:0]             scaled;
    logic [HT_W-1:0]              height_next;

    assign advance = !out_valid_reg || rsp.ready;
    assign q_pop   = advance && !q_stat.empty;

    assign ix     = CW'(q_item.query_x[CO_W-1:FRAC_BITS]);
    assign iz     = CW'(q_item.query_z[CO_W-1:FRAC_BITS]);
    assign ix1    = ix + CW'(1);
    assign iz1    = iz + CW'(1);
    assign wr_col = CW'(q_item.write_col);
    assign wr_row = CW'(q_item.write_row);

    for (genvar b = 0; b < 4; b++)
    begin : g_bank
        localparam logic RP = 1'(b / 2);
        localparam logic CP = 1'(b % 2);

        logic [CW-1:0] row_sel;
        logic [CW-1:0] col_sel;
        logic [AW-1:0] raddr;
        logic [AW-1:0] waddr;
        logic          we;

        assign row_sel = (iz[0] == RP) ? iz : iz1;
        assign col_sel = (ix[0] == CP) ? ix : ix1;
        assign raddr   = {row_sel[CW-1:1], col_sel[CW-1:1]};
        assign waddr   = {wr_row[CW-1:1], wr_col[CW-1:1]};
        assign we      = q_pop && !q_item.is_query && q_item.write_ok &&
                         (wr_row[0] == RP) && (wr_col[0] == CP);

        hm_ram #(
            .WIDTH (hm_pkg::SAMPLE_W),
            .DEPTH (DEPTH)
        ) u_ram (
            .clk   (clk),
            .we    (we),
            .waddr (waddr),
            .wdata (q_item.write_value),
            .re    (advance),
            .raddr (raddr),
            .rdata (bank_data[b])
        );
    end

    always_comb
    begin
        logic       xn;
        logic       zn;
        logic [1:0] sel_bl;
        logic [1:0] sel_br;
        logic [1:0] sel_tl;
        logic [1:0] sel_tr;
        logic [FRAC_BITS:0] fsum;

        xn     = s1_clamp_x_reg ? s1_ix0_reg : !s1_ix0_reg;
        zn     = s1_clamp_z_reg ? s1_iz0_reg : !s1_iz0_reg;
        sel_bl = {s1_iz0_reg, s1_ix0_reg};
        sel_br = {s1_iz0_reg, xn};
        sel_tl = {zn, s1_ix0_reg};
        sel_tr = {zn, xn};
        fsum   = {1'b0, s1_fx_reg} + {1'b0, s1_fz_reg};

        c_bl = signed'({2'b00, bank_data[sel_bl]});
        c_br = signed'({2'b00, bank_data[sel_br]});
        c_tl = signed'({2'b00, bank_data[sel_tl]});
        c_tr = signed'({2'b00, bank_data[sel_tr]});

        if (s1_iz0_reg)
        begin
            if (s1_fz_reg >= s1_fx_reg)
            begin
                c_br = c_bl + c_tr - c_tl;
            end
            else
            begin
                c_tl = c_tr + c_bl - c_br;
            end
        end
        else
        begin
            if (fsum < ONE_F)
            begin
                c_tr = c_tl + c_br - c_bl;
            end
            else
            begin
                c_bl = c_tl + c_br - c_tr;
            end
        end
    end

    always_comb
    begin
        logic signed [WGT_W-1:0] wfx;
        logic signed [WGT_W-1:0] wnx;

        wfx      = signed'({2'b00, s2_fx_reg});
        wnx      = ONE_W - wfx;
        top_next = s2_tl_reg * wnx + s2_tr_reg * wfx;
        bot_next = s2_bl_reg * wnx + s2_br_reg * wfx;
    end

    always_comb
    begin
        logic signed [WGT_W-1:0] wfz;
        logic signed [WGT_W-1:0] wnz;

        wfz       = signed'({2'b00, s3_fz_reg});
        wnz       = ONE_W - wfz;
        ptop_next = s3_top_reg * wfz;
        pbot_next = s3_bot_reg * wnz;
    end

    assign h_sum = H_W'(s4_pbot_reg) + H_W'(s4_ptop_reg);
    assign h_ext = h_sum[H_W-1] ? '0 : EXT_W'(h_sum[H_W-2:0]);

    if (SH > 0)
    begin : g_round
        localparam logic [EXT_W-1:0] RND = EXT_W'(1) << (SH - 1);
        assign scaled = (h_ext + RND) >> SH;
    end
    else if (SH < 0)
    begin : g_widen
        assign scaled = h_ext << (-SH);
    end
    else
    begin : g_keep
        assign scaled = h_ext;
    end

    assign height_next = (|scaled[EXT_W-1:HT_W]) ? '1 : scaled[HT_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            s4_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s1_valid_reg  <= q_pop && q_item.is_query;
            s2_valid_reg  <= s1_valid_reg;
            s3_valid_reg  <= s2_valid_reg;
            s4_valid_reg  <= s3_valid_reg;
            out_valid_reg <= s4_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_outside_reg <= q_item.outside;
            s1_fx_reg      <= q_item.query_x[FRAC_BITS-1:0];
            s1_fz_reg      <= q_item.query_z[FRAC_BITS-1:0];
            s1_ix0_reg     <= ix[0];
            s1_iz0_reg     <= iz[0];
            s1_clamp_x_reg <= q_item.clamp_x;
            s1_clamp_z_reg <= q_item.clamp_z;

            s2_outside_reg <= s1_outside_reg;
            s2_fx_reg      <= s1_fx_reg;
            s2_fz_reg      <= s1_fz_reg;
            s2_bl_reg      <= c_bl;
            s2_br_reg      <= c_br;
            s2_tl_reg      <= c_tl;
            s2_tr_reg      <= c_tr;

            s3_outside_reg <= s2_outside_reg;
            s3_fz_reg      <= s2_fz_reg;
            s3_top_reg     <= top_next;
            s3_bot_reg     <= bot_next;

            s4_outside_reg <= s3_outside_reg;
            s4_ptop_reg    <= ptop_next;
            s4_pbot_reg    <= pbot_next;

            outside_reg    <= s4_outside_reg;
            height_reg     <= s4_outside_reg ? '0 : height_next;
        end
    end

    assign rsp.valid   = out_valid_reg;
    assign rsp.height  = height_reg;
    assign rsp.outside = outside_reg;

endmodule

[rtl/core/heightmap_height_interpolate.sv]
// Height map sampler top level: front end, request queue and interpolation back end.
// Throughput: one request per cycle while the response is not stalled;
// four parity banks serve all corners in one read.
// A stalled response holds the back end; the four-entry queue takes requests until full.
// Reset clears control state and sets map_width and map_length to 256; samples stay unset.
`timescale 1ns / 1ps

module heightmap_height_interpolate #(
    parameter int MAP_SIZE  = 256,
    parameter int FRAC_BITS = 8
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [hm_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [hm_pkg::DIM_W-1:0]        cfg_data,
    hm_req_if.sink                          req,
    hm_rsp_if.source                        rsp
);

    hm_pkg::qstat_t q_stat;
    hm_pkg::item_t  q_in;
    hm_pkg::item_t  q_out;
    logic           q_push;
    logic           q_pop;

    hm_front #(
        .MAP_SIZE  (MAP_SIZE),
        .FRAC_BITS (FRAC_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req       (req),
        .q_stat    (q_stat),
        .q_push    (q_push),
        .q_item    (q_in)
    );

    hm_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .din   (q_in),
        .pop   (q_pop),
        .dout  (q_out),
        .stat  (q_stat)
    );

    hm_back #(
        .MAP_SIZE  (MAP_SIZE),
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .q_stat (q_stat),
        .q_item (q_out),
        .q_pop  (q_pop),
        .rsp    (rsp)
    );

`ifndef SYNTHESIS
    a_outside_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.outside) |-> (rsp.height == '0))
        else $error("outside response with nonzero height");

    a_queue_state: assert property (@(posedge clk) disable iff (!rst_n)
        !(q_stat.full && q_stat.empty))
        else $error("queue full and empty at once");

    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_stat.full)
        else $error("push into full queue");

    a_pop_data: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !q_stat.empty)
        else $error("pop from empty queue");
`endif

endmodule
